>>> sv/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants, register codes and types for the lidar point projection
// and depth colouring pipeline.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // field widths
  localparam int PT_W       = 32;
  localparam int PIX_W      = 16;
  localparam int COL_W      = 8;
  localparam int DEPTH_W    = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SUM_W      = 64;

  // arithmetic constants
  localparam int PROD_SHIFT = 3;
  localparam int RAMP_STEPS = 10;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW0_A = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW0_B = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW1_A = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW1_B = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW2_A = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW2_B = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEAR   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAR    = 3'd7;

  localparam logic [DEPTH_W-1:0] NEAR_RESET = 31'd65536;
  localparam logic [DEPTH_W-1:0] FAR_RESET  = 31'd3932160;

  // colour ramp segments
  localparam int SEG_W = 3;
  typedef logic [SEG_W-1:0] seg_t;
  localparam seg_t SEG_BELOW = 3'd0;
  localparam seg_t SEG_0     = 3'd1;
  localparam seg_t SEG_1     = 3'd2;
  localparam seg_t SEG_2     = 3'd3;
  localparam seg_t SEG_3     = 3'd4;
  localparam seg_t SEG_4     = 3'd5;
  localparam seg_t SEG_ABOVE = 3'd6;

  // pipeline shape
  localparam int PROJ_STAGES   = 3;
  localparam int RAMP_STAGES   = 3;
  localparam int PIX_DIV_BITS  = 16;
  localparam int RAMP_DIV_BITS = 10;
  localparam int RAMP_NUM_W    = 42;
  localparam int PIX_NUM_W     = 66;
  localparam int PIX_DEN_W     = 64;
  localparam int COLOUR_DLY    = PROJ_STAGES + 1 + PIX_DIV_BITS
                                 - (RAMP_STAGES + RAMP_DIV_BITS);
  localparam int PIPE_LAT      = PROJ_STAGES + 1 + PIX_DIV_BITS + 1;

  localparam logic [PIX_W-1:0] PIX_MAX = 16'h7fff;
  localparam logic [PIX_W-1:0] PIX_MIN = 16'h8000;

  typedef logic [CFG_DATA_W-1:0] row_word_t;
  typedef logic signed [SUM_W-1:0] row_sum_t;

  // saturate a truncated quotient magnitude to a signed pixel coordinate
  function automatic logic [PIX_W-1:0] sat_pix(input logic [PIX_W-1:0] q,
                                               input logic neg,
                                               input logic ovf,
                                               input logic front);
    logic [PIX_W-1:0] r;
    if (!front) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q[PIX_W-1]) ? PIX_MAX : q;
    end else begin
      r = (ovf || q[PIX_W-1]) ? PIX_MIN : PIX_W'(0 - q);
    end
    return r;
  endfunction

endpackage

>>> sv/lpc_div.sv
// ----------------------------------------------------------------------------
// lpc_div
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Expects num < den << QW. Side data travels with each item.
// ----------------------------------------------------------------------------
module lpc_div #(
  parameter int NW = 66,
  parameter int DW = 64,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem   [QW];
  logic [DW-1:0] dreg  [QW];
  logic [QW-1:0] qreg  [QW];
  logic [SW-1:0] sreg  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [CW-1:0] shifted;
    logic [CW-1:0] remx;
    logic [CW-1:0] diff;
    logic          ge;
    logic [QW-1:0] q_next;

    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
      assign sin = side_in;
    end else begin : g_rest
      assign rin = rem[k-1];
      assign din = dreg[k-1];
      assign qin = qreg[k-1];
      assign sin = sreg[k-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    always_comb begin
      shifted = CW'(din) << (QW - 1 - k);
      remx    = CW'(rin);
      diff    = remx - shifted;
      ge      = remx >= shifted;
      q_next  = qin;
      q_next[QW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[NW-1:0] : rin;
        dreg[k] <= din;
        qreg[k] <= q_next;
        sreg[k] <= sin;
      end
    end
  end

  assign quot     = qreg[QW-1];
  assign side_out = sreg[QW-1];

endmodule

>>> sv/lpc_proj.sv
// ----------------------------------------------------------------------------
// lpc_proj
// Three-stage 3x4 matrix times homogeneous point: products, pair sums,
// row sums. Each product is floored by 8 before summing.
// ----------------------------------------------------------------------------
module lpc_proj (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [lpc_pkg::PT_W-1:0] x,
  input  logic signed [lpc_pkg::PT_W-1:0] y,
  input  logic signed [lpc_pkg::PT_W-1:0] z,
  input  lpc_pkg::row_word_t             row_a [3],
  input  lpc_pkg::row_word_t             row_b [3],
  output lpc_pkg::row_sum_t              sums  [3]
);

  lpc_pkg::row_sum_t prod  [3][3];
  lpc_pkg::row_sum_t trans [3];
  lpc_pkg::row_sum_t pair_a [3];
  lpc_pkg::row_sum_t pair_b [3];

  logic signed [31:0] c0 [3];
  logic signed [31:0] c1 [3];
  logic signed [31:0] c2 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c0[r] = row_a[r][31:0];
      c1[r] = row_a[r][63:32];
      c2[r] = row_b[r][31:0];
    end
  end

  // stage 1: products; translation times 1.0 then floored by 8 is a shift
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= c0[r] * x;
        prod[r][1] <= c1[r] * y;
        prod[r][2] <= c2[r] * z;
        trans[r]   <= {{19{row_b[r][63]}}, row_b[r][63:32], 13'd0};
      end
    end
  end

  // stage 2: floor each product and add in pairs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        pair_a[r] <= (prod[r][0] >>> lpc_pkg::PROD_SHIFT)
                   + (prod[r][1] >>> lpc_pkg::PROD_SHIFT);
        pair_b[r] <= (prod[r][2] >>> lpc_pkg::PROD_SHIFT) + trans[r];
      end
    end
  end

  // stage 3: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sums[r] <= pair_a[r] + pair_b[r];
      end
    end
  end

endmodule

>>> sv/lpc_ramp.sv
// ----------------------------------------------------------------------------
// lpc_ramp
// Front of the depth colour ramp: scaled offset, segment search and the
// numerator 255 * (t - j*S) for the segment divider.
// ----------------------------------------------------------------------------
module lpc_ramp (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [lpc_pkg::PT_W-1:0]    x,
  input  logic [lpc_pkg::DEPTH_W-1:0]        near_depth,
  input  logic [lpc_pkg::DEPTH_W-1:0]        far_depth,
  output logic [lpc_pkg::RAMP_NUM_W-1:0]     num,
  output logic [lpc_pkg::DEPTH_W-1:0]        span,
  output lpc_pkg::seg_t                      seg
);

  logic signed [37:0] t1;
  logic signed [31:0] s1;
  logic signed [32:0] diff;

  logic [33:0]                  r2;
  logic [lpc_pkg::DEPTH_W-1:0]  s2;
  lpc_pkg::seg_t                seg2;

  logic signed [37:0] sx;
  logic signed [37:0] s_2;
  logic signed [37:0] s_4;
  logic signed [37:0] s_7;
  logic signed [37:0] s_10;
  logic signed [37:0] base;
  logic signed [37:0] rdiff;
  lpc_pkg::seg_t      seg_next;

  assign diff = 33'(x) - $signed({2'b00, near_depth});

  // stage 1: t = steps * (x - near), S = far - near
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= 38'(diff) * 38'(lpc_pkg::RAMP_STEPS);
      s1 <= $signed({1'b0, far_depth}) - $signed({1'b0, near_depth});
    end
  end

  // segment boundaries at 0, S, 2S, 4S, 7S, 10S
  always_comb begin
    sx   = 38'(s1);
    s_2  = sx <<< 1;
    s_4  = sx <<< 2;
    s_7  = (sx <<< 3) - sx;
    s_10 = sx * 38'(lpc_pkg::RAMP_STEPS);
    base = '0;
    if (t1 < 0) begin
      seg_next = lpc_pkg::SEG_BELOW;
    end else if (t1 < sx) begin
      seg_next = lpc_pkg::SEG_0;
    end else if (t1 < s_2) begin
      seg_next = lpc_pkg::SEG_1;
      base     = sx;
    end else if (t1 < s_4) begin
      seg_next = lpc_pkg::SEG_2;
      base     = s_2;
    end else if (t1 < s_7) begin
      seg_next = lpc_pkg::SEG_3;
      base     = s_4;
    end else if (t1 < s_10) begin
      seg_next = lpc_pkg::SEG_4;
      base     = s_7;
    end else begin
      seg_next = lpc_pkg::SEG_ABOVE;
    end
    rdiff = t1 - base;
  end

  // stage 2: segment and offset into it
  always_ff @(posedge clk) begin
    if (en) begin
      seg2 <= seg_next;
      r2   <= rdiff[33:0];
      s2   <= s1[lpc_pkg::DEPTH_W-1:0];
    end
  end

  // stage 3: scale offset by 255
  always_ff @(posedge clk) begin
    if (en) begin
      num  <= lpc_pkg::RAMP_NUM_W'({r2, 8'd0}) - lpc_pkg::RAMP_NUM_W'(r2);
      span <= s2;
      seg  <= seg2;
    end
  end

endmodule

>>> sv/lidar_point_project_colourize.sv
// ----------------------------------------------------------------------------
// lidar_point_project_colourize
// Projects a lidar point through a 3x4 matrix to a saturated pixel and
// colours it by depth on a ten-step ramp.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  tdata: pt_x, pt_y, pt_z
// m_axis    out  m_tvalid/m_tready  tdata: pix_u, pix_v, red, green, blue;
//                                   tuser: in_front
// cfg       in   cfg_we             cfg_addr, cfg_data
//
// One item per cycle unless m_tready stalls; the pixel path is the 16-stage divider
// behind the three-stage matrix multiply and one prep stage.
// Reset clears valid bits and loads the register reset values.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module lidar_point_project_colourize (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [95:0]                       s_tdata,  // pt_x, pt_y, pt_z
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [55:0]                       m_tdata,  // pix_u, pix_v, red, green, blue
  output logic                              m_tuser,  // in_front
  input  logic                              cfg_we,
  input  logic [lpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LAT = lpc_pkg::PIPE_LAT;

  lpc_pkg::row_word_t                row_a [3];
  lpc_pkg::row_word_t                row_b [3];
  logic [lpc_pkg::DEPTH_W-1:0]       near_depth;
  logic [lpc_pkg::DEPTH_W-1:0]       far_depth;

  logic                              en;
  logic [LAT-1:0]                    vld;
  lpc_pkg::row_sum_t                 sums [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        row_a[r] <= '0;
        row_b[r] <= '0;
      end
      near_depth <= lpc_pkg::NEAR_RESET;
      far_depth  <= lpc_pkg::FAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lpc_pkg::CFG_ROW0_A: row_a[0] <= cfg_data;
        lpc_pkg::CFG_ROW0_B: row_b[0] <= cfg_data;
        lpc_pkg::CFG_ROW1_A: row_a[1] <= cfg_data;
        lpc_pkg::CFG_ROW1_B: row_b[1] <= cfg_data;
        lpc_pkg::CFG_ROW2_A: row_a[2] <= cfg_data;
        lpc_pkg::CFG_ROW2_B: row_b[2] <= cfg_data;
        lpc_pkg::CFG_NEAR:   near_depth <= cfg_data[lpc_pkg::DEPTH_W-1:0];
        lpc_pkg::CFG_FAR:    far_depth  <= cfg_data[lpc_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output register is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // projection
  lpc_proj u_proj (
    .clk   (clk),
    .en    (en),
    .x     (s_tdata[31:0]),
    .y     (s_tdata[63:32]),
    .z     (s_tdata[95:64]),
    .row_a (row_a),
    .row_b (row_b),
    .sums  (sums)
  );

  // prep: rounded numerators, doubled denominator, overflow check
  logic signed [lpc_pkg::PIX_NUM_W-1:0] nu_c;
  logic signed [lpc_pkg::PIX_NUM_W-1:0] nv_c;
  logic [lpc_pkg::PIX_NUM_W-1:0]        mu_c;
  logic [lpc_pkg::PIX_NUM_W-1:0]        mv_c;
  logic [lpc_pkg::PIX_DEN_W-1:0]        d2_c;
  logic [79:0]                          dlim_c;

  always_comb begin
    nu_c   = (lpc_pkg::PIX_NUM_W'(sums[0]) <<< 1) + lpc_pkg::PIX_NUM_W'(sums[2]);
    nv_c   = (lpc_pkg::PIX_NUM_W'(sums[1]) <<< 1) + lpc_pkg::PIX_NUM_W'(sums[2]);
    mu_c   = nu_c[lpc_pkg::PIX_NUM_W-1] ? lpc_pkg::PIX_NUM_W'(-nu_c) : nu_c;
    mv_c   = nv_c[lpc_pkg::PIX_NUM_W-1] ? lpc_pkg::PIX_NUM_W'(-nv_c) : nv_c;
    d2_c   = {sums[2][lpc_pkg::SUM_W-2:0], 1'b0};
    dlim_c = {d2_c, 16'd0};
  end

  logic [lpc_pkg::PIX_NUM_W-1:0] mu;
  logic [lpc_pkg::PIX_NUM_W-1:0] mv;
  logic [lpc_pkg::PIX_DEN_W-1:0] d2;
  logic [2:0]                    side_u;
  logic [1:0]                    side_v;

  always_ff @(posedge clk) begin
    if (en) begin
      mu     <= mu_c;
      mv     <= mv_c;
      d2     <= d2_c;
      side_u <= {!sums[2][lpc_pkg::SUM_W-1] && (|sums[2]),
                 80'(mu_c) >= dlim_c, nu_c[lpc_pkg::PIX_NUM_W-1]};
      side_v <= {80'(mv_c) >= dlim_c, nv_c[lpc_pkg::PIX_NUM_W-1]};
    end
  end

  // pixel dividers
  logic [lpc_pkg::PIX_W-1:0] qu;
  logic [lpc_pkg::PIX_W-1:0] qv;
  logic [2:0]                side_uo;
  logic [1:0]                side_vo;

  lpc_div #(
    .NW (lpc_pkg::PIX_NUM_W),
    .DW (lpc_pkg::PIX_DEN_W),
    .QW (lpc_pkg::PIX_DIV_BITS),
    .SW (3)
  ) u_div_u (
    .clk      (clk),
    .en       (en),
    .num      (mu),
    .den      (d2),
    .side_in  (side_u),
    .quot     (qu),
    .side_out (side_uo)
  );

  lpc_div #(
    .NW (lpc_pkg::PIX_NUM_W),
    .DW (lpc_pkg::PIX_DEN_W),
    .QW (lpc_pkg::PIX_DIV_BITS),
    .SW (2)
  ) u_div_v (
    .clk      (clk),
    .en       (en),
    .num      (mv),
    .den      (d2),
    .side_in  (side_v),
    .quot     (qv),
    .side_out (side_vo)
  );

  // colour ramp
  logic [lpc_pkg::RAMP_NUM_W-1:0] rnum;
  logic [lpc_pkg::DEPTH_W-1:0]    rspan;
  lpc_pkg::seg_t                  rseg;
  logic [lpc_pkg::RAMP_DIV_BITS-1:0] rq;
  lpc_pkg::seg_t                  rseg_o;

  lpc_ramp u_ramp (
    .clk        (clk),
    .en         (en),
    .x          (s_tdata[31:0]),
    .near_depth (near_depth),
    .far_depth  (far_depth),
    .num        (rnum),
    .span       (rspan),
    .seg        (rseg)
  );

  lpc_div #(
    .NW (lpc_pkg::RAMP_NUM_W),
    .DW (lpc_pkg::DEPTH_W),
    .QW (lpc_pkg::RAMP_DIV_BITS),
    .SW (lpc_pkg::SEG_W)
  ) u_div_ramp (
    .clk      (clk),
    .en       (en),
    .num      (rnum),
    .den      (rspan),
    .side_in  (rseg),
    .quot     (rq),
    .side_out (rseg_o)
  );

  // segment to colour, 8-bit wrap kept
  logic [lpc_pkg::COL_W-1:0] term;
  logic [23:0]               rgb_c;

  always_comb begin
    term = rq[lpc_pkg::COL_W-1:0];
    unique case (rseg_o)
      lpc_pkg::SEG_BELOW: rgb_c = {8'h00, 8'h00, 8'hff};
      lpc_pkg::SEG_0:     rgb_c = {8'h00, term,  8'hff};
      lpc_pkg::SEG_1:     rgb_c = {8'h00, 8'hff, ~term};
      lpc_pkg::SEG_2:     rgb_c = {term,  8'hff, 8'h00};
      lpc_pkg::SEG_3:     rgb_c = {8'hff, ~term, 8'h00};
      lpc_pkg::SEG_4:     rgb_c = {8'hff, 8'h00, term};
      default:            rgb_c = {8'hff, 8'h00, 8'hff};
    endcase
  end

  // align colour with the pixel path
  logic [23:0] cdly [lpc_pkg::COLOUR_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      cdly[0] <= rgb_c;
      for (int i = 1; i < lpc_pkg::COLOUR_DLY; i++) begin
        cdly[i] <= cdly[i-1];
      end
    end
  end

  // output register, colour packed red, green, blue from bit 32 up
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[15:0]  <= lpc_pkg::sat_pix(qu, side_uo[0], side_uo[1], side_uo[2]);
      m_tdata[31:16] <= lpc_pkg::sat_pix(qv, side_vo[0], side_vo[1], side_uo[2]);
      m_tdata[55:32] <= {cdly[lpc_pkg::COLOUR_DLY-1][7:0],
                         cdly[lpc_pkg::COLOUR_DLY-1][15:8],
                         cdly[lpc_pkg::COLOUR_DLY-1][23:16]};
      m_tuser        <= side_uo[2];
    end
  end

endmodule

>>> tb/tb_lidar_point_project_colourize.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_point_project_colourize
// Streams lidar points through the projection and colour pipeline under
// several matrix and depth ramp settings and random idling on both sides.
// Each accepted point is predicted here and checked field by field against
// the result stream, in order.
// ----------------------------------------------------------------------------
module tb_lidar_point_project_colourize;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } point_t;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    logic        front;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [lpc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // local copy of the block's registers
  logic [63:0] mat_a [3];
  logic [63:0] mat_b [3];
  logic [30:0] near_cfg = lpc_pkg::NEAR_RESET;
  logic [30:0] far_cfg  = lpc_pkg::FAR_RESET;

  point_t points_pending [$];
  pixel_t pixels_expected [$];
  int     send_idle = 0;
  int     recv_idle = 0;
  int     errors = 0;
  int     stall_left = 0;
  logic   stall_req = 1'b0;

  lidar_point_project_colourize u_top (.*);

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // homogeneous row dot product, each term floored by the product shift
  function automatic longint row_dot(logic [63:0] ra, logic [63:0] rb, point_t p);
    longint acc;
    acc = (longint'($signed(ra[31:0])) * longint'(p.x)) >>> lpc_pkg::PROD_SHIFT;
    acc += (longint'($signed(ra[63:32])) * longint'(p.y)) >>> lpc_pkg::PROD_SHIFT;
    acc += (longint'($signed(rb[31:0])) * longint'(p.z)) >>> lpc_pkg::PROD_SHIFT;
    acc += (longint'($signed(rb[63:32])) * 64'sd65536) >>> lpc_pkg::PROD_SHIFT;
    return acc;
  endfunction

  // rounded divide, truncating toward zero, saturated to 16 bits
  function automatic logic [15:0] pixel_coord(longint num, longint den);
    logic signed [69:0] nn, dd, q;
    nn = num;
    dd = den;
    q = (nn * 2 + dd) / (dd * 2);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [7:0] ramp(longint t, longint s);
    longint q;
    q = (255 * t) / s;
    return q[7:0];
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t res;
    longint n0, n1, den, t, s;
    n0  = row_dot(mat_a[0], mat_b[0], p);
    n1  = row_dot(mat_a[1], mat_b[1], p);
    den = row_dot(mat_a[2], mat_b[2], p);
    res.front = den > 0;
    res.u = res.front ? pixel_coord(n0, den) : 16'd0;
    res.v = res.front ? pixel_coord(n1, den) : 16'd0;
    // depth colour ramp on x
    t = 10 * (longint'(p.x) - longint'(near_cfg));
    s = longint'(far_cfg) - longint'(near_cfg);
    if (t < 0) begin
      res.r = 0; res.g = 0; res.b = 8'hff;
    end else if (t < s) begin
      res.r = 0; res.g = ramp(t, s); res.b = 8'hff;
    end else if (t < 2 * s) begin
      res.r = 0; res.g = 8'hff; res.b = 8'd255 - ramp(t - s, s);
    end else if (t < 4 * s) begin
      res.r = ramp(t - 2 * s, s); res.g = 8'hff; res.b = 0;
    end else if (t < 7 * s) begin
      res.r = 8'hff; res.g = 8'd255 - ramp(t - 4 * s, s); res.b = 0;
    end else if (t < 10 * s) begin
      res.r = 8'hff; res.g = 0; res.b = ramp(t - 7 * s, s);
    end else begin
      res.r = 8'hff; res.g = 0; res.b = 8'hff;
    end
    return res;
  endfunction

  // append a point to the pending queue
  function automatic void add_point(point_t p);
    points_pending = {points_pending, p};
  endfunction

  // driver: offer pending points, record the expected pixel on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        pixels_expected = {pixels_expected, project_point(points_pending.pop_front())};
      end
      if (points_pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        s_tvalid <= 1'b1;
        s_tdata  <= points_pending[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stall_req) begin
      stall_left <= 300;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= recv_idle;
    end
  end

  // monitor: compare each result item with the oldest expectation
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_expected.size() == 0) begin
        $error("unexpected result item %h", m_tdata);
        errors++;
      end else begin
        e = pixels_expected.pop_front();
        if (m_tdata[15:0] !== e.u) begin
          $error("pix_u expected %h got %h", e.u, m_tdata[15:0]); errors++;
        end
        if (m_tdata[31:16] !== e.v) begin
          $error("pix_v expected %h got %h", e.v, m_tdata[31:16]); errors++;
        end
        if (m_tuser !== e.front) begin
          $error("in_front expected %b got %b", e.front, m_tuser); errors++;
        end
        if (m_tdata[39:32] !== e.r) begin
          $error("red expected %h got %h", e.r, m_tdata[39:32]); errors++;
        end
        if (m_tdata[47:40] !== e.g) begin
          $error("green expected %h got %h", e.g, m_tdata[47:40]); errors++;
        end
        if (m_tdata[55:48] !== e.b) begin
          $error("blue expected %h got %h", e.b, m_tdata[55:48]); errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [lpc_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      lpc_pkg::CFG_ROW0_A: mat_a[0] = val;
      lpc_pkg::CFG_ROW0_B: mat_b[0] = val;
      lpc_pkg::CFG_ROW1_A: mat_a[1] = val;
      lpc_pkg::CFG_ROW1_B: mat_b[1] = val;
      lpc_pkg::CFG_ROW2_A: mat_a[2] = val;
      lpc_pkg::CFG_ROW2_B: mat_b[2] = val;
      lpc_pkg::CFG_NEAR:   near_cfg = val[30:0];
      default:             far_cfg  = val[30:0];
    endcase
  endtask

  task automatic load_setup(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                            logic [63:0] r1b, logic [63:0] r2a, logic [63:0] r2b,
                            logic [63:0] near_v, logic [63:0] far_v);
    write_reg(lpc_pkg::CFG_ROW0_A, r0a);
    write_reg(lpc_pkg::CFG_ROW0_B, r0b);
    write_reg(lpc_pkg::CFG_ROW1_A, r1a);
    write_reg(lpc_pkg::CFG_ROW1_B, r1b);
    write_reg(lpc_pkg::CFG_ROW2_A, r2a);
    write_reg(lpc_pkg::CFG_ROW2_B, r2b);
    write_reg(lpc_pkg::CFG_NEAR, near_v);
    write_reg(lpc_pkg::CFG_FAR, far_v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (points_pending.size() > 0 || s_tvalid || pixels_expected.size() > 0)
      @(posedge clk);
  endtask

  function automatic point_t random_point();
    point_t p;
    longint span;
    case ($urandom_range(0, 3))
      0: begin
        p.x = $urandom; p.y = $urandom; p.z = $urandom;
      end
      1: begin
        // plausible scene: forward range up to 60 m, lateral within 20 m
        p.x = $urandom_range(0, 60 << 16);
        p.y = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        p.z = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
      end
      default: begin
        // depth spread over the ramp and a bit past both ends
        span = longint'(far_cfg) - longint'(near_cfg);
        if (span <= 0) span = 4096;
        p.x = 32'(longint'(near_cfg) - span / 8
                  + longint'($urandom % (span * 5 / 4 + 1)));
        p.y = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        p.z = $urandom;
      end
    endcase
    return p;
  endfunction

  // real camera matrix, lidar x forward, y left, z up
  localparam logic [63:0] CAM_R0A = {-32'sd17043944, 32'sd3616039};
  localparam logic [63:0] CAM_R0B = {32'sd4096, 32'sd0};
  localparam logic [63:0] CAM_R1A = {32'sd0, 32'sd2262316};
  localparam logic [63:0] CAM_R1B = {32'sd0, -32'sd17133602};
  localparam logic [63:0] CAM_R2A = {32'sd0, 32'sd4096};
  localparam logic [63:0] CAM_R2B = {32'sd0, 32'sd0};

  // stimulus and phase control
  initial begin
    point_t p;
    longint span;
    mat_a = '{default: '0};
    mat_b = '{default: '0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed points with the camera matrix and the reset ramp
    load_setup(CAM_R0A, CAM_R0B, CAM_R1A, CAM_R1B, CAM_R2A, CAM_R2B,
               64'(lpc_pkg::NEAR_RESET), 64'(lpc_pkg::FAR_RESET));
    add_point('{z: 0, y: 0, x: 0});                                 // at camera
    add_point('{z: 32'sd65536, y: 0, x: -32'sd65536});              // behind
    add_point('{z: 32'h7fffffff, y: 32'h7fffffff, x: 32'h7fffffff});
    add_point('{z: 32'h80000000, y: 32'h80000000, x: 32'h80000000});
    add_point('{z: 0, y: 50 << 16, x: 32'sd65536});                 // off to the left
    add_point('{z: -(50 << 16), y: -(50 << 16), x: 32'sd65536});
    span = longint'(lpc_pkg::FAR_RESET) - longint'(lpc_pkg::NEAR_RESET);
    for (int k = 0; k <= 21; k++) begin
      p.x = 32'(longint'(lpc_pkg::NEAR_RESET) + span * k / 20);
      p.y = 32'sd65536 * k;
      p.z = -32'sd30000 * k;
      add_point(p);
    end
    p.x = lpc_pkg::NEAR_RESET - 1; p.y = 0; p.z = 0;               // just below near
    add_point(p);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 61; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 61; end
        default: begin send_idle = 18; recv_idle = 18; end
      endcase
      case (ph)
        0: load_setup(CAM_R0A, CAM_R0B, CAM_R1A, CAM_R1B, CAM_R2A, CAM_R2B,
                      64'd0, 64'h7fffffff);
        1: load_setup({2{32'h7fffffff}}, {2{32'h7fffffff}}, {2{32'h80000000}},
                      {2{32'h80000000}}, {2{32'h7fffffff}}, {2{32'h7fffffff}},
                      64'h7fffffff, 64'd0);
        2: load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      64'd65536, 64'd65536);
        3: load_setup({2{32'h80000000}}, {2{32'h80000000}}, {2{32'h7fffffff}},
                      {2{32'h7fffffff}}, {2{32'h80000000}}, {32'h7fffffff, 32'h80000000},
                      64'd1000, 64'd1010);
        default: load_setup(
            {$urandom_range(0, 8191) - 4096, $urandom_range(0, 1 << 23)},
            {$urandom_range(0, 1 << 20), $urandom_range(0, 8191) - 4096},
            {$urandom_range(0, 8191) - 4096, $urandom_range(0, 1 << 23)},
            {$urandom_range(0, 1 << 20), $urandom_range(0, 8191) - 4096},
            {$urandom_range(0, 255), $urandom_range(2048, 8192)},
            {$urandom_range(0, 4096), $urandom_range(0, 255)},
            64'($urandom_range(0, 4 << 16)), 64'($urandom_range(5 << 16, 100 << 16)));
      endcase
      for (int i = 0; i < 235; i++)
        add_point(random_point());
      if (ph == 4) begin
        // receiver holds off long enough for the pipeline to back up
        @(negedge clk);
        stall_req = 1'b1;
        wait (stall_left != 0);
        @(negedge clk);
        stall_req = 1'b0;
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (pixels_expected.size() != 0) errors++;
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> lidar_point_project_colourize.f
sv/lpc_pkg.sv
sv/lpc_div.sv
sv/lpc_proj.sv
sv/lpc_ramp.sv
sv/lidar_point_project_colourize.sv
tb/tb_lidar_point_project_colourize.sv
